// ===== rtl/mst_pkg.sv =====
// shared types and constants of the minimum spanning tree engine
package mst_pkg;

   localparam int MAX_NODES_DEF   = 32;
   localparam int MAX_EDGES_DEF   = 256;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int NODE_FIELD_W    = 6;
   localparam int TOTAL_BITS      = 21;
   localparam int ERR_W           = 2;
   localparam int QUEUE_DEPTH     = 2;
   localparam logic [NODE_FIELD_W-1:0] NODE_COUNT_RST = 6'd32;

   localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVF = 2'd1;
   localparam logic [ERR_W-1:0] ERR_BAD = 2'd2;

   typedef enum logic [1:0] {
      KIND_STORE,
      KIND_BAD,
      KIND_OVF
   } edge_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FIND_A,
      S_FIND_B,
      S_UNION,
      S_SUMMARY
   } back_state_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

endpackage

// ===== rtl/mst_req_if.sv =====
// edge input channel
interface mst_req_if #(parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF);
   logic                                 valid;
   logic                                 ready;
   logic        [mst_pkg::NODE_FIELD_W-1:0] node_a;
   logic        [mst_pkg::NODE_FIELD_W-1:0] node_b;
   logic signed [WEIGHT_BITS-1:0]        weight;
   logic                                 last_edge;

   modport source (output valid, node_a, node_b, weight, last_edge, input ready);
   modport sink (input valid, node_a, node_b, weight, last_edge, output ready);
endinterface

// ===== rtl/mst_rsp_if.sv =====
// result output channel
interface mst_rsp_if #(parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF);
   logic                                  valid;
   logic                                  ready;
   logic                                  edge_valid;
   logic        [mst_pkg::NODE_FIELD_W-1:0] tree_node_a;
   logic        [mst_pkg::NODE_FIELD_W-1:0] tree_node_b;
   logic signed [WEIGHT_BITS-1:0]         edge_weight;
   logic signed [mst_pkg::TOTAL_BITS-1:0] total_weight;
   logic        [mst_pkg::ERR_W-1:0]      error;
   logic                                  final_res;

   modport source (output valid, edge_valid, tree_node_a, tree_node_b, edge_weight,
                   total_weight, error, final_res, input ready);
   modport sink (input valid, edge_valid, tree_node_a, tree_node_b, edge_weight,
                 total_weight, error, final_res, output ready);
endinterface

// ===== rtl/mst_front.sv =====
// input front: node count register, edge classification and queue push
module mst_front #(
   parameter int MAX_NODES   = mst_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES   = mst_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mst_req_if.sink                             req_ch,
   input  logic                                csr_wr_en,
   input  logic [mst_pkg::NODE_FIELD_W-1:0]    csr_wr_data,
   output mst_pkg::queue_ctl_type              q_ctl_out,
   input  logic                                q_full,
   output logic [2+1+2*((MAX_NODES>1)?$clog2(MAX_NODES):1)+WEIGHT_BITS-1:0] q_data
);
   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_EDGES + 1);

   logic [mst_pkg::NODE_FIELD_W-1:0] node_count_ff, node_count_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   int                               lim_int;
   logic                             bad, ovf, acc;
   mst_pkg::edge_kind_type           kind;
   logic [NW-1:0]                    a_idx, b_idx;

   assign req_ch.ready = !q_full;
   assign acc = req_ch.valid && !q_full;

   always_comb begin
      lim_int = (int'(node_count_ff) > MAX_NODES) ? MAX_NODES : int'(node_count_ff);
      bad = (req_ch.node_a == '0) || (req_ch.node_b == '0) ||
            (int'(req_ch.node_a) > lim_int) || (int'(req_ch.node_b) > lim_int);
      ovf = int'(cnt_ff) >= MAX_EDGES;
      if (bad) begin
         kind = mst_pkg::KIND_BAD;
      end else if (ovf) begin
         kind = mst_pkg::KIND_OVF;
      end else begin
         kind = mst_pkg::KIND_STORE;
      end
      a_idx = NW'(int'(req_ch.node_a) - 1);
      b_idx = NW'(int'(req_ch.node_b) - 1);
      cnt_in = cnt_ff;
      if (acc) begin
         if (req_ch.last_edge) begin
            cnt_in = '0;
         end else if (kind == mst_pkg::KIND_STORE) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
   end

   assign q_ctl_out.push = acc;
   assign q_ctl_out.full = q_full;
   assign q_data = {kind, req_ch.last_edge, a_idx, b_idx, req_ch.weight};

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= mst_pkg::NODE_COUNT_RST;
         cnt_ff        <= '0;
      end else begin
         node_count_ff <= node_count_in;
         cnt_ff        <= cnt_in;
      end
   end
endmodule

// ===== rtl/mst_queue.sv =====
// short fifo between front and back
module mst_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mst_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mst_pkg::queue_ctl_type q_ctl_in,
   input  logic [WIDTH-1:0]       wr_data,
   output logic                   full,
   output logic                   rd_valid,
   input  logic                   rd_pop,
   output logic [WIDTH-1:0]       rd_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NC = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [NC-1:0]    n_ff, n_in;
   logic             do_push, do_pop;

   assign full     = (int'(n_ff) == DEPTH);
   assign rd_valid = (n_ff != '0);
   assign rd_data  = slot_ff[rp_ff];
   assign do_push  = q_ctl_in.push && !full;
   assign do_pop   = rd_pop && rd_valid;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (do_push) begin
         wp_in = (int'(wp_ff) == DEPTH - 1) ? '0 : wp_ff + PW'(1);
      end
      if (do_pop) begin
         rp_in = (int'(rp_ff) == DEPTH - 1) ? '0 : rp_ff + PW'(1);
      end
      n_in = n_ff + NC'(do_push) - NC'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff  <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end
endmodule

// ===== rtl/mst_back.sv =====
// back end: edge store, selection scan, union-find and result register
module mst_back #(
   parameter int MAX_NODES   = mst_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES   = mst_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_pop,
   input  logic [2+1+2*((MAX_NODES>1)?$clog2(MAX_NODES):1)+WEIGHT_BITS-1:0] q_data,
   mst_rsp_if.source rsp_ch
);
   localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SNW = $clog2(MAX_NODES + 1);
   localparam int EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW  = $clog2(MAX_EDGES + 1);
   localparam int WB  = WEIGHT_BITS;
   localparam int TW  = mst_pkg::TOTAL_BITS;
   localparam int SW  = ((WB > TW) ? WB : TW) + 1;
   localparam int MW  = 2 * NW + WB;
   localparam int FW  = mst_pkg::NODE_FIELD_W;
   localparam int TOT_MAX = 2 ** (TW - 1) - 1;
   localparam int TOT_MIN = -(2 ** (TW - 1));

   mst_pkg::back_state_type state_ff, state_in;

   logic [MW-1:0]    edge_mem [MAX_EDGES];
   logic [MW-1:0]    memq_ff;
   logic             mem_we;
   logic [EA-1:0]    mem_wa, mem_ra;
   logic [NW-1:0]    parent_ff [MAX_NODES];
   logic             pval_ff [MAX_NODES];
   logic             par_we, par_clr;
   logic [NW-1:0]    par_wa, par_wd;

   logic [CW-1:0]    cnt_ff, cnt_in, sel_ff, sel_in, iss_ff, iss_in, pidx_ff, pidx_in;
   logic [1:0]       flags_ff, flags_in;
   logic signed [TW-1:0] total_ff, total_in;
   logic             pend_ff, pend_in;
   logic             have_prev_ff, have_prev_in, have_best_ff, have_best_in;
   logic signed [WB-1:0] prev_w_ff, prev_w_in, best_w_ff, best_w_in;
   logic [CW-1:0]    prev_idx_ff, prev_idx_in, best_idx_ff, best_idx_in;
   logic [NW-1:0]    best_a_ff, best_a_in, best_b_ff, best_b_in;
   logic [NW-1:0]    node_ff, node_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [SNW-1:0]   steps_ff, steps_in, sa_ff, sa_in, sb_ff, sb_in;

   logic             o_valid_ff, o_valid_in, o_edge_ff, o_edge_in, o_fin_ff, o_fin_in;
   logic [FW-1:0]    o_a_ff, o_a_in, o_b_ff, o_b_in;
   logic signed [WB-1:0] o_w_ff, o_w_in;
   logic signed [TW-1:0] o_tot_ff, o_tot_in;
   logic [mst_pkg::ERR_W-1:0] o_err_ff, o_err_in, err_code;

   mst_pkg::edge_kind_type q_kind;
   logic             q_last;
   logic [NW-1:0]    q_a, q_b;
   logic signed [WB-1:0] q_w, m_w;
   logic [NW-1:0]    m_a, m_b, par_rd;
   logic             out_free, gt_prev, lt_best;
   logic [CW-1:0]    n_run, sel_nx;
   logic signed [SW-1:0] sum;

   assign q_kind = mst_pkg::edge_kind_type'(q_data[MW+2:MW+1]);
   assign q_last = q_data[MW];
   assign q_a    = q_data[MW-1:NW+WB];
   assign q_b    = q_data[NW+WB-1:WB];
   assign q_w    = $signed(q_data[WB-1:0]);
   assign m_a    = memq_ff[MW-1:NW+WB];
   assign m_b    = memq_ff[NW+WB-1:WB];
   assign m_w    = $signed(memq_ff[WB-1:0]);
   assign par_rd = pval_ff[node_ff] ? parent_ff[node_ff] : node_ff;
   assign out_free = !o_valid_ff || rsp_ch.ready;
   assign err_code = flags_ff[1] ? mst_pkg::ERR_BAD :
                     (flags_ff[0] ? mst_pkg::ERR_OVF : mst_pkg::ERR_OK);
   assign sum = SW'(total_ff) + SW'(best_w_ff);
   assign sel_nx = sel_ff + CW'(1);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; sel_in = sel_ff; iss_in = iss_ff; pidx_in = pidx_ff;
      flags_in = flags_ff; total_in = total_ff; pend_in = pend_ff;
      have_prev_in = have_prev_ff; have_best_in = have_best_ff;
      prev_w_in = prev_w_ff; prev_idx_in = prev_idx_ff;
      best_w_in = best_w_ff; best_idx_in = best_idx_ff;
      best_a_in = best_a_ff; best_b_in = best_b_ff;
      node_in = node_ff; steps_in = steps_ff;
      ra_in = ra_ff; rb_in = rb_ff; sa_in = sa_ff; sb_in = sb_ff;
      o_valid_in = o_valid_ff && !rsp_ch.ready;
      o_edge_in = o_edge_ff; o_fin_in = o_fin_ff; o_a_in = o_a_ff; o_b_in = o_b_ff;
      o_w_in = o_w_ff; o_tot_in = o_tot_ff; o_err_in = o_err_ff;
      q_pop = 1'b0;
      mem_we = 1'b0; mem_wa = cnt_ff[EA-1:0]; mem_ra = iss_ff[EA-1:0];
      par_we = 1'b0; par_clr = 1'b0; par_wa = ra_ff; par_wd = rb_ff;
      n_run = cnt_ff;
      gt_prev = !have_prev_ff || (m_w > prev_w_ff) ||
                ((m_w == prev_w_ff) && (pidx_ff > prev_idx_ff));
      lt_best = !have_best_ff || (m_w < best_w_ff);

      case (state_ff)
         mst_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_kind)
                  mst_pkg::KIND_STORE: begin
                     mem_we = 1'b1;
                     n_run  = cnt_ff + CW'(1);
                  end
                  mst_pkg::KIND_BAD: flags_in = flags_ff | 2'b10;
                  mst_pkg::KIND_OVF: flags_in = flags_ff | 2'b01;
                  default: flags_in = flags_ff;
               endcase
               cnt_in = n_run;
               if (q_last) begin
                  sel_in = '0; iss_in = '0; pend_in = 1'b0;
                  have_prev_in = 1'b0; have_best_in = 1'b0;
                  state_in = (n_run == '0) ? mst_pkg::S_SUMMARY : mst_pkg::S_SCAN;
               end
            end
         end
         mst_pkg::S_SCAN: begin
            if (pend_ff && gt_prev && lt_best) begin
               have_best_in = 1'b1;
               best_w_in = m_w; best_idx_in = pidx_ff;
               best_a_in = m_a; best_b_in = m_b;
            end
            if (iss_ff < cnt_ff) begin
               pend_in = 1'b1;
               pidx_in = iss_ff;
               iss_in  = iss_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  node_in  = best_a_ff;
                  steps_in = '0;
                  state_in = mst_pkg::S_FIND_A;
               end
            end
         end
         mst_pkg::S_FIND_A: begin
            if (par_rd == node_ff) begin
               ra_in = node_ff; sa_in = steps_ff;
               node_in = best_b_ff; steps_in = '0;
               state_in = mst_pkg::S_FIND_B;
            end else begin
               node_in = par_rd; steps_in = steps_ff + SNW'(1);
            end
         end
         mst_pkg::S_FIND_B: begin
            if (par_rd == node_ff) begin
               rb_in = node_ff; sb_in = steps_ff;
               state_in = mst_pkg::S_UNION;
            end else begin
               node_in = par_rd; steps_in = steps_ff + SNW'(1);
            end
         end
         mst_pkg::S_UNION: begin
            if (ra_ff == rb_ff || out_free) begin
               if (ra_ff != rb_ff) begin
                  par_we = 1'b1;
                  if (sa_ff > sb_ff) begin
                     par_wa = rb_ff; par_wd = ra_ff;
                  end else begin
                     par_wa = ra_ff; par_wd = rb_ff;
                  end
                  if (sum > SW'(TOT_MAX)) begin
                     total_in = TW'(TOT_MAX);
                  end else if (sum < SW'(TOT_MIN)) begin
                     total_in = TW'(TOT_MIN);
                  end else begin
                     total_in = TW'(sum);
                  end
                  o_valid_in = 1'b1; o_edge_in = 1'b1; o_fin_in = 1'b0;
                  o_a_in = FW'(int'(best_a_ff) + 1);
                  o_b_in = FW'(int'(best_b_ff) + 1);
                  o_w_in = best_w_ff; o_tot_in = total_in; o_err_in = err_code;
               end
               sel_in = sel_nx;
               if (sel_nx == cnt_ff) begin
                  state_in = mst_pkg::S_SUMMARY;
               end else begin
                  have_prev_in = 1'b1; prev_w_in = best_w_ff; prev_idx_in = best_idx_ff;
                  have_best_in = 1'b0; iss_in = '0; pend_in = 1'b0;
                  state_in = mst_pkg::S_SCAN;
               end
            end
         end
         mst_pkg::S_SUMMARY: begin
            if (out_free) begin
               o_valid_in = 1'b1; o_edge_in = 1'b0; o_fin_in = 1'b1;
               o_a_in = '0; o_b_in = '0; o_w_in = '0;
               o_tot_in = total_ff; o_err_in = err_code;
               cnt_in = '0; total_in = '0; flags_in = '0; par_clr = 1'b1;
               state_in = mst_pkg::S_IDLE;
            end
         end
         default: state_in = mst_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         edge_mem[mem_wa] <= {q_a, q_b, q_w};
      end
      memq_ff <= edge_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         parent_ff[par_wa] <= par_wd;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         if (reset || par_clr) begin
            pval_ff[i] <= 1'b0;
         end else if (par_we && (int'(par_wa) == i)) begin
            pval_ff[i] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mst_pkg::S_IDLE;
         cnt_ff <= '0; flags_ff <= '0; total_ff <= '0;
         pend_ff <= 1'b0; o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in; flags_ff <= flags_in; total_ff <= total_in;
         pend_ff <= pend_in; o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in; iss_ff <= iss_in; pidx_ff <= pidx_in;
      have_prev_ff <= have_prev_in; have_best_ff <= have_best_in;
      prev_w_ff <= prev_w_in; prev_idx_ff <= prev_idx_in;
      best_w_ff <= best_w_in; best_idx_ff <= best_idx_in;
      best_a_ff <= best_a_in; best_b_ff <= best_b_in;
      node_ff <= node_in; steps_ff <= steps_in;
      ra_ff <= ra_in; rb_ff <= rb_in; sa_ff <= sa_in; sb_ff <= sb_in;
      o_edge_ff <= o_edge_in; o_fin_ff <= o_fin_in; o_a_ff <= o_a_in; o_b_ff <= o_b_in;
      o_w_ff <= o_w_in; o_tot_ff <= o_tot_in; o_err_ff <= o_err_in;
   end

   assign rsp_ch.valid        = o_valid_ff;
   assign rsp_ch.edge_valid   = o_edge_ff;
   assign rsp_ch.tree_node_a  = o_a_ff;
   assign rsp_ch.tree_node_b  = o_b_ff;
   assign rsp_ch.edge_weight  = o_w_ff;
   assign rsp_ch.total_weight = o_tot_ff;
   assign rsp_ch.error        = o_err_ff;
   assign rsp_ch.final_res    = o_fin_ff;
endmodule

// ===== rtl/minimum_spanning_tree_engine_unit.sv =====
// top level of the minimum spanning tree engine
// Edges are taken one per cycle, while the queue is not full, through a two-entry
// queue and written to the edge store, one per cycle while the back end is idle. The
// edge marked last starts a run: for each of the n stored edges the back end scans
// the whole store through its single read port to pick the next edge in weight order,
// walks both endpoints to their roots (one parent step per cycle), then unions the
// roots and posts the tree edge if they differ, waiting while the result register is
// still held; a summary result ends the run. No item is accepted once the queue
// fills during a run. The parent store is cleared at once after each run; there is
// no clearing pass after reset.
module minimum_spanning_tree_engine_unit #(
   parameter int MAX_NODES   = mst_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES   = mst_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   mst_req_if.sink                          req_ch,
   mst_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [mst_pkg::NODE_FIELD_W-1:0] csr_wr_data
);
   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int RW = 2 + 1 + 2 * NW + WEIGHT_BITS;

   mst_pkg::queue_ctl_type q_ctl;
   logic [RW-1:0]          push_data, pop_data;
   logic                   q_full, q_valid, q_pop;

   mst_front #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS))
   u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .q_ctl_out(q_ctl), .q_full(q_full), .q_data(push_data)
   );

   mst_queue #(.WIDTH(RW), .DEPTH(mst_pkg::QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .q_ctl_in(q_ctl), .wr_data(push_data),
      .full(q_full), .rd_valid(q_valid), .rd_pop(q_pop), .rd_data(pop_data)
   );

   mst_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS))
   u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_data(pop_data), .rsp_ch(rsp_ch)
   );
endmodule

// ===== rtl/mst_checker.sv =====
// port level checks of the minimum spanning tree engine and their binding
module mst_checker #(
   parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             edge_valid,
   input logic                             final_res,
   input logic [mst_pkg::NODE_FIELD_W-1:0] tree_node_a,
   input logic [mst_pkg::NODE_FIELD_W-1:0] tree_node_b,
   input logic signed [WEIGHT_BITS-1:0]    edge_weight,
   input logic [mst_pkg::ERR_W-1:0]        error
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (edge_valid != final_res))
      else $error("result is neither a tree edge nor the summary");

   a_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && final_res |-> tree_node_a == '0 && tree_node_b == '0 &&
                                 edge_weight == '0)
      else $error("summary carries edge fields");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (error == mst_pkg::ERR_OK || error == mst_pkg::ERR_OVF ||
                     error == mst_pkg::ERR_BAD))
      else $error("undefined error code");
endmodule

bind minimum_spanning_tree_engine_unit mst_checker #(.WEIGHT_BITS(WEIGHT_BITS)) u_mst_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .edge_valid(rsp_ch.edge_valid), .final_res(rsp_ch.final_res),
   .tree_node_a(rsp_ch.tree_node_a), .tree_node_b(rsp_ch.tree_node_b),
   .edge_weight(rsp_ch.edge_weight), .error(rsp_ch.error)
);

// ===== sim/tb_minimum_spanning_tree_engine_unit.sv =====
// testbench for the minimum spanning tree engine: random edge graphs checked against a tree predictor
module tb_minimum_spanning_tree_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_LIMIT     = mst_pkg::MAX_NODES_DEF;
   localparam int EDGE_LIMIT     = mst_pkg::MAX_EDGES_DEF;
   localparam int NODE_W         = mst_pkg::NODE_FIELD_W;
   localparam int WEIGHT_W       = mst_pkg::WEIGHT_BITS_DEF;
   localparam int TOT_W          = mst_pkg::TOTAL_BITS;
   localparam int ERR_BITS       = mst_pkg::ERR_W;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 60;
   localparam logic [1:0] FLAG_OVF = 2'b01;
   localparam logic [1:0] FLAG_BAD = 2'b10;
   localparam longint TOTAL_HI = (64'sd1 <<< (TOT_W - 1)) - 1;
   localparam longint TOTAL_LO = -(64'sd1 <<< (TOT_W - 1));

   typedef struct packed {
      logic                       edge_valid;
      logic [NODE_W-1:0]          tree_node_a;
      logic [NODE_W-1:0]          tree_node_b;
      logic signed [WEIGHT_W-1:0] edge_weight;
      logic signed [TOT_W-1:0]    total_weight;
      logic [ERR_BITS-1:0]        error;
      logic                       final_res;
   } tree_result_type;

   class mst_scoreboard;
      logic [NODE_W-1:0] node_count;
      int end_a[$];
      int end_b[$];
      int edge_w[$];
      logic [1:0] drop_flags;
      tree_result_type awaited[$];
      int failures;

      function new();
         node_count = mst_pkg::NODE_COUNT_RST;
         drop_flags = '0;
         failures = 0;
      endfunction

      function int walk_root(ref int parent[NODE_LIMIT], input int n, output int steps);
         int c;
         c = 0;
         while (parent[n] != n && c < NODE_LIMIT) begin
            n = parent[n];
            c++;
         end
         steps = c;
         return n;
      endfunction

      function void build_tree();
         int order[$];
         int parent[NODE_LIMIT];
         int i, j, ra, rb, sa, sb, cnt, e;
         longint total;
         logic [ERR_BITS-1:0] err;
         tree_result_type r;
         err = drop_flags[1] ? mst_pkg::ERR_BAD :
               (drop_flags[0] ? mst_pkg::ERR_OVF : mst_pkg::ERR_OK);
         for (i = 0; i < end_a.size(); i++) begin
            j = order.size();
            while (j > 0 && edge_w[order[j-1]] > edge_w[i]) j--;
            order.insert(j, i);
         end
         for (i = 0; i < NODE_LIMIT; i++) parent[i] = i;
         total = 0;
         cnt = 0;
         for (i = 0; i < order.size(); i++) begin
            e = order[i];
            ra = walk_root(parent, end_a[e], sa);
            rb = walk_root(parent, end_b[e], sb);
            if (ra == rb) continue;
            if (sa > sb) parent[rb] = ra;
            else parent[ra] = rb;
            total += edge_w[e];
            if (total > TOTAL_HI) total = TOTAL_HI;
            if (total < TOTAL_LO) total = TOTAL_LO;
            if (cnt < NODE_LIMIT - 1) begin
               r.edge_valid   = 1'b1;
               r.tree_node_a  = NODE_W'(end_a[e] + 1);
               r.tree_node_b  = NODE_W'(end_b[e] + 1);
               r.edge_weight  = WEIGHT_W'(edge_w[e]);
               r.total_weight = TOT_W'(total);
               r.error        = err;
               r.final_res    = 1'b0;
               awaited.insert(awaited.size(), r);
               cnt++;
            end
         end
         r.edge_valid   = 1'b0;
         r.tree_node_a  = '0;
         r.tree_node_b  = '0;
         r.edge_weight  = '0;
         r.total_weight = TOT_W'(total);
         r.error        = err;
         r.final_res    = 1'b1;
         awaited.insert(awaited.size(), r);
         end_a.delete();
         end_b.delete();
         edge_w.delete();
         drop_flags = '0;
      endfunction

      function void note_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                              logic signed [WEIGHT_W-1:0] w, logic last);
         int lim;
         lim = (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
         if (a == 0 || b == 0 || a > lim || b > lim) drop_flags |= FLAG_BAD;
         else if (end_a.size() >= EDGE_LIMIT) drop_flags |= FLAG_OVF;
         else begin
            end_a.insert(end_a.size(), int'(a) - 1);
            end_b.insert(end_b.size(), int'(b) - 1);
            edge_w.insert(edge_w.size(), int'(w));
         end
         if (last) build_tree();
      endfunction

      function void compare_field(string name, longint exp_v, longint got_v);
         if (exp_v != got_v) begin
            failures++;
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name, exp_v,
                     got_v);
         end
      endfunction

      function void check_result(tree_result_type got);
         tree_result_type exp_r;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t unexpected result transfer: got %p", $realtime, got);
            return;
         end
         exp_r = awaited.pop_front();
         compare_field("edge_valid", exp_r.edge_valid, got.edge_valid);
         compare_field("tree_node_a", exp_r.tree_node_a, got.tree_node_a);
         compare_field("tree_node_b", exp_r.tree_node_b, got.tree_node_b);
         compare_field("edge_weight", exp_r.edge_weight, got.edge_weight);
         compare_field("total_weight", exp_r.total_weight, got.total_weight);
         compare_field("error", exp_r.error, got.error);
         compare_field("final_res", exp_r.final_res, got.final_res);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [NODE_W-1:0] csr_wr_data;

   mst_req_if req_ch ();
   mst_rsp_if rsp_ch ();

   minimum_spanning_tree_engine_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mst_scoreboard sb = new();
   bit no_gaps;
   int hold_request;
   int idle_count = 0;
   int random_sent;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side
   initial begin
      int stall;
      tree_result_type got;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
               rsp_ch.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.edge_valid   = rsp_ch.edge_valid;
         got.tree_node_a  = rsp_ch.tree_node_a;
         got.tree_node_b  = rsp_ch.tree_node_b;
         got.edge_weight  = rsp_ch.edge_weight;
         got.total_weight = rsp_ch.total_weight;
         got.error        = rsp_ch.error;
         got.final_res    = rsp_ch.final_res;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   task automatic send_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                            input logic signed [WEIGHT_W-1:0] w, input logic last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.node_a    = a;
      req_ch.node_b    = b;
      req_ch.weight    = w;
      req_ch.last_edge = last;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_edge(a, b, w, last);
   endtask

   task automatic send_graph(input int n_edges, input int noise_pct, input bit close);
      int lim, k;
      logic [NODE_W-1:0] a, b;
      logic signed [WEIGHT_W-1:0] w;
      lim = (sb.node_count > NODE_LIMIT) ? NODE_LIMIT : sb.node_count;
      for (k = 0; k < n_edges; k++) begin
         if (lim == 0 || $urandom_range(0, 99) < noise_pct) begin
            a = NODE_W'($urandom_range(0, 63));
            b = NODE_W'($urandom_range(0, 63));
         end else begin
            a = NODE_W'($urandom_range(1, lim));
            b = NODE_W'($urandom_range(1, lim));
         end
         if ($urandom_range(0, 2) == 0) w = WEIGHT_W'($signed($urandom_range(0, 6)) - 3);
         else w = WEIGHT_W'($urandom);
         send_edge(a, b, w, close && (k == n_edges - 1));
      end
   endtask

   // let every expected result arrive, then give the block time to settle
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [NODE_W-1:0] v);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.node_count = v;
   endtask

   initial begin
      int sz, g;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.node_a    = '0;
      req_ch.node_b    = '0;
      req_ch.weight    = '0;
      req_ch.last_edge = 1'b0;
      no_gaps          = 1'b0;
      hold_request     = 0;
      random_sent      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, ties, self loop, empty graph
      send_edge(6'd1, 6'd32, 16'sh7fff, 1'b0);
      send_edge(6'd32, 6'd2, -16'sh8000, 1'b0);
      send_edge(6'd2, 6'd1, 16'sd5, 1'b0);
      send_edge(6'd3, 6'd3, 16'sd0, 1'b0);
      send_edge(6'd4, 6'd3, 16'sd5, 1'b0);
      send_edge(6'd1, 6'd2, 16'sd5, 1'b1);
      send_edge(6'd0, 6'd7, 16'sd9, 1'b1);
      drain();
      write_node_count(6'd0);
      send_edge(6'd1, 6'd1, 16'sd7, 1'b1);
      drain();
      write_node_count(6'd63);
      send_edge(6'd32, 6'd31, -16'sd1, 1'b0);
      send_edge(6'd33, 6'd1, 16'sd2, 1'b1);
      drain();
      write_node_count(6'd1);
      send_edge(6'd1, 6'd1, 16'sd3, 1'b0);
      send_edge(6'd1, 6'd2, 16'sd4, 1'b1);
      drain();

      // full store, then overflow
      write_node_count(6'd32);
      no_gaps = 1'b1;
      send_graph(EDGE_LIMIT, 0, 1'b0);
      send_edge(6'd3, 6'd4, 16'sd9, 1'b1);
      drain();

      // result side held off while graphs keep coming
      hold_request = HOLD_CYCLES;
      for (g = 0; g < 4; g++) send_graph(6, 10, 1'b1);
      no_gaps = 1'b0;
      drain();

      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: write_node_count(6'd1);
            1: write_node_count(6'd2);
            2: write_node_count(6'd32);
            3: write_node_count(6'd63);
            4: write_node_count($urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63)));
            default: write_node_count(6'($urandom_range(3, 31)));
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         for (g = 0; g < 3; g++) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 12);
            send_graph(sz, 15, 1'b1);
            random_sent += sz;
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (sb.awaited.size() != 0) begin
         sb.failures++;
         $display("%0t %0d results never arrived", $realtime, sb.awaited.size());
      end
      if (sb.failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
